// File: design/bfat_pkg.sv
// Package for the bloom filter add/test block: widths, hash constants,
// request and register codes, controller states and memory handshake types.
// Depends on nothing; every other design file imports it.
package bfat_pkg;

  localparam int KEY_W      = 64;
  localparam int HALF_W     = 32;
  localparam int FB_W       = 21;
  localparam int PC_W       = 5;
  localparam int CFG_W      = FB_W;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_PROBES = 16;

  localparam logic [KEY_W-1:0] HASH_MUL_A = 64'h517cc1b727220a95;
  localparam logic [KEY_W-1:0] HASH_MUL_B = 64'h6c62272e07bb0142;
  localparam int FOLD_SHIFT = 32;

  localparam int HASH_STEPS = 8;
  localparam int HASH_CNT_W = $clog2(HASH_STEPS);

  localparam int MOD_DIGITS = 8;
  localparam int MOD_STEPS  = KEY_W / MOD_DIGITS;
  localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

  localparam int ROW_W     = 64;
  localparam int ROW_SEL_W = $clog2(ROW_W);

  localparam logic [FB_W-1:0] FILTER_BITS_RST = 21'h100000;
  localparam logic [PC_W-1:0] PROBE_COUNT_RST = 5'd7;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TEST = 1'b1
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_BITS = 1'b0,
    CFG_PROBE_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_MEM,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic go;
    logic set;
  } mem_req_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic hit;
  } mem_rsp_t;

endpackage

// File: design/bfat_hash.sv
// Probe hash unit: two 64-bit multiplies by constants, each with a fold,
// computed step by step on one shared 32x32 multiplier.
// Depends on bfat_pkg.
module bfat_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bfat_pkg::KEY_W-1:0] key_x,
  output logic                      done,
  output logic [bfat_pkg::KEY_W-1:0] hash
);
  import bfat_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [HASH_CNT_W-1:0] step_r;
  logic [KEY_W-1:0]      op_r;
  logic [KEY_W-1:0]      acc_r;
  logic [KEY_W-1:0]      mul_r;
  logic [KEY_W-1:0]      hash_r;

  logic [1:0]        sub;
  logic              phase;
  logic [KEY_W-1:0]  kmul;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [KEY_W-1:0]  mul_p;
  logic [HALF_W-1:0] hi_sum;
  logic [KEY_W-1:0]  prod;
  logic [KEY_W-1:0]  prod_fold;

  always_comb begin
    sub       = step_r[1:0];
    phase     = step_r[2];
    kmul      = phase ? HASH_MUL_B : HASH_MUL_A;
    mul_a     = (sub == 2'd2) ? op_r[KEY_W-1:HALF_W] : op_r[HALF_W-1:0];
    mul_b     = (sub == 2'd1) ? kmul[KEY_W-1:HALF_W] : kmul[HALF_W-1:0];
    mul_p     = mul_a * mul_b;
    hi_sum    = acc_r[KEY_W-1:HALF_W] + mul_r[HALF_W-1:0];
    prod      = {hi_sum, acc_r[HALF_W-1:0]};
    prod_fold = prod ^ (prod >> FOLD_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == HASH_CNT_W'(HASH_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_p;
    if (start) begin
      op_r <= key_x;
    end else if (busy_r) begin
      unique case (sub)
        2'd0: ;
        2'd1: acc_r <= mul_r;
        2'd2: acc_r[KEY_W-1:HALF_W] <= hi_sum;
        2'd3: begin
          if (phase) begin
            hash_r <= prod_fold;
          end else begin
            op_r <= prod_fold;
          end
        end
      endcase
    end
  end

  assign done = done_r;
  assign hash = hash_r;

endmodule

// File: design/bfat_mod.sv
// Remainder unit: reduces a 64-bit hash modulo the bit count, eight
// dividend bits per cycle by restoring compare and subtract.
// Depends on bfat_pkg.
module bfat_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bfat_pkg::KEY_W-1:0] dividend,
  input  logic [bfat_pkg::FB_W-1:0]  modulus,
  output logic                      done,
  output logic [bfat_pkg::FB_W-1:0]  rem
);
  import bfat_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic [KEY_W-1:0]     dvd_r;
  logic [FB_W-1:0]      rem_r;
  logic [FB_W-1:0]      rem_nxt;

  always_comb begin
    logic [FB_W:0]   t;
    logic [FB_W-1:0] r;
    r = rem_r;
    for (int j = 0; j < MOD_DIGITS; j++) begin
      t = {r, dvd_r[KEY_W-1-j]};
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
      end
      r = t[FB_W-1:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << MOD_DIGITS;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: design/bfat_bitmem.sv
// Filter bit array held as 64-bit rows in a synchronous memory, with the
// clearing sweep after reset and the read, or for an add the read-modify-write, of one bit.
// Depends on bfat_pkg.
module bfat_bitmem #(
  parameter longint unsigned MAX_BITS = 1048576
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bfat_pkg::mem_req_t           req,
  input  logic [$clog2(MAX_BITS)-1:0]  bit_idx,
  output bfat_pkg::mem_rsp_t           rsp
);
  import bfat_pkg::*;

  localparam int DEPTH = int'((MAX_BITS + ROW_W - 1) / ROW_W);
  localparam int RAW   = $clog2(DEPTH);

  logic [ROW_W-1:0] filter_mem [DEPTH];

  logic                 clr_busy_r;
  logic [RAW-1:0]       clr_addr_r;
  logic                 pend_r;
  logic                 done_r;
  logic                 set_r;
  logic                 hit_r;
  logic [ROW_SEL_W-1:0] sel_r;
  logic [RAW-1:0]       wa_r;
  logic [ROW_W-1:0]     rdata_r;

  logic [RAW-1:0]   row;
  logic             we;
  logic [RAW-1:0]   wa;
  logic [ROW_W-1:0] wd;

  always_comb begin
    row = RAW'(bit_idx >> ROW_SEL_W);
    we  = clr_busy_r | (pend_r & set_r);
    wa  = clr_busy_r ? clr_addr_r : wa_r;
    wd  = clr_busy_r ? '0 : (rdata_r | (ROW_W'(1) << sel_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      pend_r     <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r <= pend_r;
      pend_r <= req.go & ~clr_busy_r;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == RAW'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      sel_r <= bit_idx[ROW_SEL_W-1:0];
      wa_r  <= row;
      set_r <= req.set;
    end
    if (pend_r) begin
      hit_r <= rdata_r[sel_r];
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= filter_mem[row];
    if (we) begin
      filter_mem[wa] <= wd;
    end
  end

  assign rsp.ready = ~clr_busy_r;
  assign rsp.done  = done_r;
  assign rsp.hit   = hit_r;

endmodule

// File: design/bloom_filter_add_test.sv
// Bloom filter with add and test requests over a bit array of MAX_BITS bits.
// After reset the array is cleared one 64-bit row per cycle, MAX_BITS/64
// rows in all (16384 at the default size); busy stays high until then.
// Each probe passes through the hash unit (two 64-bit multiplies on one
// 32x32 multiplier), then the remainder unit (eight dividend bits per
// cycle), then the row read or read-modify-write and handoff, and a test
// stops at the first clear bit. Results cannot be held off: each is shown
// for one cycle with out_valid, and a new word may be started in that same
// cycle.
module bloom_filter_add_test #(
  parameter longint unsigned MAX_BITS = 1048576
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_req_type,
  input  logic [bfat_pkg::KEY_W-1:0]      in_key,
  output logic                            out_valid,
  output logic                            out_maybe_present,
  input  logic                            cfg_we,
  input  logic [bfat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfat_pkg::CFG_W-1:0]      cfg_wdata
);
  import bfat_pkg::*;

  localparam int IW = $clog2(MAX_BITS);
  localparam logic [KEY_W-1:0] MAX_BITS_W = KEY_W'(MAX_BITS);

  state_t state_r;
  state_t state_nxt;

  logic [FB_W-1:0]  filter_bits_r;
  logic [PC_W-1:0]  probe_count_r;
  logic [KEY_W-1:0] key_r;
  logic             req_r;
  logic [FB_W-1:0]  m_r;
  logic [PC_W-1:0]  n_r;
  logic [PC_W-1:0]  probe_r;
  logic             ans_r;
  logic             out_valid_r;
  logic             out_mp_r;

  logic [FB_W-1:0]  m_eff;
  logic [PC_W-1:0]  n_eff;
  logic             accept;
  logic             miss;
  logic             last;
  logic             hash_go;
  logic [KEY_W-1:0] hash_in;
  logic             hash_done;
  logic [KEY_W-1:0] hash_val;
  logic             mod_go;
  logic             mod_done;
  logic [FB_W-1:0]  mod_rem;
  mem_req_t         mem_req;
  mem_rsp_t         mem_rsp;

  always_comb begin
    if (filter_bits_r == '0) begin
      m_eff = FB_W'(1);
    end else if (KEY_W'(filter_bits_r) > MAX_BITS_W) begin
      m_eff = FB_W'(MAX_BITS_W);
    end else begin
      m_eff = filter_bits_r;
    end
    if (probe_count_r > PC_W'(MAX_PROBES)) begin
      n_eff = PC_W'(MAX_PROBES);
    end else begin
      n_eff = probe_count_r;
    end
  end

  assign accept = start & (state_r == ST_IDLE);
  assign miss   = (req_r == REQ_TEST) & ~mem_rsp.hit;
  assign last   = (probe_r == PC_W'(n_r - 1'b1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (mem_rsp.ready) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          state_nxt = (n_eff == '0) ? ST_FIN : ST_HASH;
        end
      end
      ST_HASH: if (hash_done) state_nxt = ST_MOD;
      ST_MOD:  if (mod_done) state_nxt = ST_MEM;
      ST_MEM: begin
        if (mem_rsp.done) begin
          state_nxt = (miss || last) ? ST_FIN : ST_HASH;
        end
      end
      ST_FIN: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    hash_go     = 1'b0;
    hash_in     = key_r ^ KEY_W'(PC_W'(probe_r + 1'b1));
    mod_go      = 1'b0;
    mem_req.go  = 1'b0;
    mem_req.set = (req_r == REQ_ADD);
    unique case (state_r)
      ST_IDLE: begin
        hash_go = start && (n_eff != '0);
        hash_in = in_key;
      end
      ST_HASH: mod_go = hash_done;
      ST_MOD:  mem_req.go = mod_done;
      ST_MEM:  hash_go = mem_rsp.done && !miss && !last;
      ST_CLEAR, ST_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      filter_bits_r <= FILTER_BITS_RST;
      probe_count_r <= PROBE_COUNT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_FIN);
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FILTER_BITS: filter_bits_r <= cfg_wdata[FB_W-1:0];
          CFG_PROBE_COUNT: probe_count_r <= cfg_wdata[PC_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= in_key;
      req_r   <= in_req_type;
      m_r     <= m_eff;
      n_r     <= n_eff;
      probe_r <= '0;
      ans_r   <= 1'b1;
    end else if ((state_r == ST_MEM) && mem_rsp.done) begin
      if (miss) begin
        ans_r <= 1'b0;
      end
      if (!miss && !last) begin
        probe_r <= probe_r + 1'b1;
      end
    end
    if (state_r == ST_FIN) begin
      out_mp_r <= (req_r == REQ_TEST) & ans_r;
    end
  end

  bfat_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_go),
    .key_x (hash_in),
    .done  (hash_done),
    .hash  (hash_val)
  );

  bfat_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_go),
    .dividend (hash_val),
    .modulus  (m_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  bfat_bitmem #(
    .MAX_BITS (MAX_BITS)
  ) u_bitmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .bit_idx (IW'(mod_rem)),
    .rsp     (mem_rsp)
  );

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_mp_r;

endmodule

// File: design/bfat_checker.sv
// Port-level checker for the bloom filter block, attached by bind.
// Depends on bfat_pkg and on the top level bloom_filter_add_test.
module bfat_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_req_type,
  input logic out_valid,
  input logic out_maybe_present
);
  import bfat_pkg::*;

  logic last_type_r;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      last_type_r <= in_req_type;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted word");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a word in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_add_answers_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (last_type_r == REQ_ADD)) |-> !out_maybe_present)
    else $error("add request answered with a set bit");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind bloom_filter_add_test bfat_checker u_bfat_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_req_type       (in_req_type),
  .out_valid         (out_valid),
  .out_maybe_present (out_maybe_present)
);
